### hw/rtl/page_slot_list_manager_top_assert.svh
// Assertion macros for the page slot list manager checker.
// Depends on nothing; included by the checker file only.
`ifndef PAGE_SLOT_LIST_MANAGER_TOP_ASSERT_SVH
`define PAGE_SLOT_LIST_MANAGER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PSLM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PSLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pslm_pkg.sv
// Shared types and constants of the page slot list manager.
// Used by the interfaces, the controller, the datapath, the top level and the checker.
package pslm_pkg;

    localparam int unsigned MAX_SLOTS = 512;
    localparam int unsigned SLOT_W    = 10;
    localparam int unsigned ADDR_W    = $clog2(MAX_SLOTS);
    localparam int unsigned RB_W      = 12;
    localparam int unsigned OFF_W     = 23;
    localparam int unsigned PROD_W    = ADDR_W + RB_W;
    localparam int unsigned CFG_W     = 12;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned STATUS_W  = 2;

    localparam logic [SLOT_W-1:0] NULL_SLOT    = SLOT_W'(MAX_SLOTS);
    localparam logic [SLOT_W-1:0] CNT_MAX      = '1;
    localparam logic [OFF_W-1:0]  HEADER_BYTES = OFF_W'(32);
    localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET   = SLOT_W'(512);
    localparam logic [RB_W-1:0]   RECORD_BYTES_RESET = RB_W'(9);

    typedef enum logic [KIND_W-1:0] {
        K_FORMAT = 2'd0,
        K_INSERT = 2'd1,
        K_ERASE  = 2'd2,
        K_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT   = 1'b0,
        CFG_RECORD_BYTES = 1'b1
    } t_cfg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic fmt_step;
        logic fmt_end;
        logic rd_free;
        logic ins_upd;
        logic set_full;
        logic rd_cur;
        logic walk_adv;
        logic ers_nxt;
        logic ers_fix;
        logic ers_free;
        logic set_nf;
        logic rd_slot;
        logic qry_link;
        logic qry_head;
        logic mul;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fmt_zero;
        logic fmt_last;
        logic free_empty;
        logic cur_null;
        logic cur_hit;
        logic steps_over;
        logic slot_in;
        logic slot_null;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/pslm_in_if.sv
// Request channel of the page slot list manager: valid, ready and the request fields.
// Depends on pslm_pkg.
interface pslm_in_if
    import pslm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output kind, output slot, input ready);
    modport sink   (input valid, input kind, input slot, output ready);
endinterface

### hw/rtl/pslm_out_if.sv
// Result channel of the page slot list manager: valid, ready and the result fields.
// Depends on pslm_pkg.
interface pslm_out_if
    import pslm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic [SLOT_W-1:0]   link_slot;
    logic [OFF_W-1:0]    byte_offset;
    logic [SLOT_W-1:0]   used_count;
    logic [SLOT_W-1:0]   free_count;
    logic                page_empty;

    modport source (
        output valid, output status, output result_slot, output link_slot,
        output byte_offset, output used_count, output free_count, output page_empty,
        input ready
    );
    modport sink (
        input valid, input status, input result_slot, input link_slot,
        input byte_offset, input used_count, input free_count, input page_empty,
        output ready
    );
endinterface

### hw/rtl/pslm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pslm_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 512,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pslm_ctrl.sv
// Controller state machine of the page slot list manager.
// Depends on pslm_pkg; drives the datapath through t_cmd and reads t_sts.
module pslm_ctrl
    import pslm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [KIND_W-1:0] i_req_kind,
    input  t_sts              i_sts,
    output t_cmd              o_cmd,
    output logic              o_req_ready
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_FMT      = 11'b000_0000_0010,
        S_INS      = 11'b000_0000_0100,
        S_ERS_CHK  = 11'b000_0000_1000,
        S_ERS_RD   = 11'b000_0001_0000,
        S_ERS_NXT  = 11'b000_0010_0000,
        S_ERS_FIX  = 11'b000_0100_0000,
        S_ERS_FREE = 11'b000_1000_0000,
        S_QRY      = 11'b001_0000_0000,
        S_MUL      = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.load = 1'b1;
                    case (t_kind'(i_req_kind))
                        K_FORMAT: n_state = S_FMT;
                        K_INSERT: begin
                            cmd.rd_free = 1'b1;
                            n_state     = S_INS;
                        end
                        K_ERASE:  n_state = S_ERS_CHK;
                        K_QUERY: begin
                            cmd.rd_slot = 1'b1;
                            n_state     = S_QRY;
                        end
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_FMT: begin
                if (i_sts.fmt_zero) begin
                    cmd.fmt_end = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    cmd.fmt_step = 1'b1;
                    if (i_sts.fmt_last) begin
                        cmd.fmt_end = 1'b1;
                        n_state     = S_DONE;
                    end
                end
            end
            S_INS: begin
                if (i_sts.free_empty) begin
                    cmd.set_full = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    cmd.ins_upd = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_ERS_CHK: begin
                if (!i_sts.slot_in || i_sts.cur_null || i_sts.steps_over) begin
                    cmd.set_nf = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    cmd.rd_cur = 1'b1;
                    n_state    = i_sts.cur_hit ? S_ERS_NXT : S_ERS_RD;
                end
            end
            S_ERS_RD: begin
                cmd.walk_adv = 1'b1;
                n_state      = S_ERS_CHK;
            end
            S_ERS_NXT: begin
                cmd.ers_nxt = 1'b1;
                n_state     = S_ERS_FIX;
            end
            S_ERS_FIX: begin
                cmd.ers_fix = 1'b1;
                n_state     = S_ERS_FREE;
            end
            S_ERS_FREE: begin
                cmd.ers_free = 1'b1;
                n_state      = S_MUL;
            end
            S_QRY: begin
                if (i_sts.slot_in) begin
                    cmd.qry_link = 1'b1;
                    n_state      = S_MUL;
                end else if (i_sts.slot_null) begin
                    cmd.qry_head = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    cmd.set_nf = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd       = cmd;
    assign o_req_ready = (r_state == S_IDLE);

endmodule

### hw/rtl/pslm_dp.sv
// Datapath of the page slot list manager: link RAM, list heads, counts, walk and result registers.
// Depends on pslm_pkg and pslm_ram; controlled through t_cmd, reports through t_sts.
module pslm_dp
    import pslm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [SLOT_W-1:0]    i_slot,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [SLOT_W-1:0]    o_result_slot,
    output logic [SLOT_W-1:0]    o_link_slot,
    output logic [OFF_W-1:0]     o_byte_offset,
    output logic [SLOT_W-1:0]    o_used_count,
    output logic [SLOT_W-1:0]    o_free_count,
    output logic                 o_page_empty
);

    function automatic logic [SLOT_W-1:0] cnt_inc(input logic [SLOT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] cnt_dec(input logic [SLOT_W-1:0] v);
        return (v == '0) ? '0 : v - SLOT_W'(1);
    endfunction

    // Configuration and list state.
    logic [SLOT_W-1:0] r_slot_count;
    logic [RB_W-1:0]   r_record_bytes;
    logic [SLOT_W-1:0] r_free_head;
    logic [SLOT_W-1:0] r_used_head;
    logic [SLOT_W-1:0] r_used_total;
    logic [SLOT_W-1:0] r_free_total;
    logic              r_out_valid;

    // Working registers of the request in progress.
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_prev;
    logic [SLOT_W-1:0] r_steps;
    logic [ADDR_W-1:0] r_fmt_idx;
    logic [SLOT_W-1:0] r_res;
    logic [SLOT_W-1:0] r_link;
    t_status           r_status;
    logic              r_empty;
    logic [PROD_W-1:0] r_prod;
    logic              r_off_en;

    // Output register.
    logic [STATUS_W-1:0] r_o_status;
    logic [SLOT_W-1:0]   r_o_res;
    logic [SLOT_W-1:0]   r_o_link;
    logic [OFF_W-1:0]    r_o_boff;
    logic [SLOT_W-1:0]   r_o_used;
    logic [SLOT_W-1:0]   r_o_free;
    logic                r_o_empty;

    logic [SLOT_W-1:0] n_eff;
    logic [SLOT_W-1:0] fmt_next;
    logic              fmt_last;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    assign n_eff    = (r_slot_count > NULL_SLOT) ? NULL_SLOT : r_slot_count;
    assign fmt_next = {1'b0, r_fmt_idx} + SLOT_W'(1);
    assign fmt_last = (fmt_next == n_eff);

    assign o_sts.fmt_zero   = (n_eff == '0);
    assign o_sts.fmt_last   = fmt_last;
    assign o_sts.free_empty = (r_free_head >= NULL_SLOT);
    assign o_sts.cur_null   = (r_cur >= NULL_SLOT);
    assign o_sts.cur_hit    = (r_cur == r_slot);
    assign o_sts.steps_over = (r_steps > NULL_SLOT);
    assign o_sts.slot_in    = (r_slot < NULL_SLOT);
    assign o_sts.slot_null  = (r_slot == NULL_SLOT);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Link RAM ports: only one command writes in any cycle.
    always_comb begin
        ram_raddr = r_cur[ADDR_W-1:0];
        if (i_cmd.rd_free) begin
            ram_raddr = r_free_head[ADDR_W-1:0];
        end else if (i_cmd.rd_slot) begin
            ram_raddr = i_slot[ADDR_W-1:0];
        end else if (i_cmd.rd_cur) begin
            ram_raddr = r_cur[ADDR_W-1:0];
        end

        ram_we    = 1'b0;
        ram_waddr = r_cur[ADDR_W-1:0];
        ram_wdata = r_free_head;
        if (i_cmd.fmt_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_fmt_idx;
            ram_wdata = fmt_last ? NULL_SLOT : fmt_next;
        end else if (i_cmd.ins_upd) begin
            ram_we    = 1'b1;
            ram_waddr = r_free_head[ADDR_W-1:0];
            ram_wdata = r_used_head;
        end else if (i_cmd.ers_fix) begin
            ram_we    = (r_prev < NULL_SLOT);
            ram_waddr = r_prev[ADDR_W-1:0];
            ram_wdata = r_link;
        end else if (i_cmd.ers_free) begin
            ram_we    = 1'b1;
        end
    end

    pslm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count   <= SLOT_COUNT_RESET;
            r_record_bytes <= RECORD_BYTES_RESET;
            r_free_head    <= NULL_SLOT;
            r_used_head    <= NULL_SLOT;
            r_used_total   <= '0;
            r_free_total   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SLOT_COUNT:   r_slot_count   <= i_cfg_data[SLOT_W-1:0];
                    CFG_RECORD_BYTES: r_record_bytes <= i_cfg_data[RB_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.fmt_end) begin
                r_free_head  <= (n_eff == '0) ? NULL_SLOT : '0;
                r_used_head  <= NULL_SLOT;
                r_used_total <= '0;
                r_free_total <= n_eff;
            end
            if (i_cmd.ins_upd) begin
                r_free_head  <= ram_rdata;
                r_used_head  <= r_free_head;
                r_free_total <= cnt_dec(r_free_total);
                r_used_total <= cnt_inc(r_used_total);
            end
            if (i_cmd.ers_fix && (r_prev >= NULL_SLOT)) begin
                r_used_head <= r_link;
            end
            if (i_cmd.ers_free) begin
                r_free_head  <= r_cur;
                r_used_total <= cnt_dec(r_used_total);
                r_free_total <= cnt_inc(r_free_total);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot    <= i_slot;
            r_cur     <= r_used_head;
            r_prev    <= NULL_SLOT;
            r_steps   <= '0;
            r_fmt_idx <= '0;
            r_res     <= (i_kind inside {K_ERASE, K_QUERY}) ? i_slot : NULL_SLOT;
            r_link    <= NULL_SLOT;
            r_status  <= ST_OK;
            r_empty   <= 1'b0;
            r_off_en  <= 1'b0;
        end
        if (i_cmd.fmt_step) begin
            r_fmt_idx <= fmt_next[ADDR_W-1:0];
        end
        if (i_cmd.ins_upd) begin
            r_res  <= r_free_head;
            r_link <= r_used_head;
        end
        if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.set_nf) begin
            r_status <= ST_NOT_FOUND;
        end
        if (i_cmd.walk_adv) begin
            r_prev  <= r_cur;
            r_cur   <= ram_rdata;
            r_steps <= r_steps + SLOT_W'(1);
        end
        if (i_cmd.ers_nxt || i_cmd.qry_link) begin
            r_link <= ram_rdata;
        end
        if (i_cmd.ers_free) begin
            r_empty <= (r_used_total <= SLOT_W'(1));
        end
        if (i_cmd.qry_head) begin
            r_link <= r_used_head;
        end
        if (i_cmd.mul) begin
            r_prod   <= PROD_W'(r_res[ADDR_W-1:0]) * PROD_W'(r_record_bytes);
            r_off_en <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_res    <= r_res;
            r_o_link   <= r_link;
            r_o_boff   <= r_off_en ? (HEADER_BYTES + OFF_W'(r_prod)) : '0;
            r_o_used   <= r_used_total;
            r_o_free   <= r_free_total;
            r_o_empty  <= r_empty;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_result_slot = r_o_res;
    assign o_link_slot   = r_o_link;
    assign o_byte_offset = r_o_boff;
    assign o_used_count  = r_o_used;
    assign o_free_count  = r_o_free;
    assign o_page_empty  = r_o_empty;

endmodule

### hw/rtl/page_slot_list_manager_top.sv
// Top level of the page slot list manager: controller, datapath and channel wiring.
// Depends on pslm_pkg, pslm_in_if, pslm_out_if, pslm_ctrl and pslm_dp.
//
// The block keeps the record slots of one storage page on two singly linked
// lists, a free list and an in-use list, with one link word per slot held in a
// 512-entry link RAM with one write port, one read port and a registered read.
// Requests are taken one at a time and each yields exactly one result. A
// successful insert, an erase that finds its slot and a next query of a real
// slot pass through the registered offset multiplier before the result is
// offered, while an insert into a full page, a failed erase and a next query of
// null or of a slot above it do not; a format chains the slots, writing one link
// per cycle, and an erase walks the in-use list with one RAM read and its
// registered data per entry passed over. The pace is set by the single link RAM
// read port, the list walk and the registered offset multiplier. A result sits
// in an output register, so the next request is accepted while an earlier
// result still waits to be taken. The link RAM is not cleared after reset: links
// become meaningful once a format has been run, and until then the free list is
// empty so inserts report full. Configuration registers (slot_count at index 0,
// record_bytes at index 1) are written through the plain write port and must
// only be changed while the block is idle.
module page_slot_list_manager_top
    import pslm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    pslm_in_if.sink              i_req,
    pslm_out_if.source           o_rsp
);

    // Command and status bundles between the controller and the datapath.
    t_cmd cmd;
    t_sts sts;
    logic req_ready;

    // The controller only accepts a request in its idle state; the request
    // fields are consumed in the same cycle as the acceptance.
    pslm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_kind  (i_req.kind),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_req_ready (req_ready)
    );

    // The datapath holds the configuration, the list heads and counts, the
    // link RAM and the output register that drives the result channel.
    pslm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_req.kind),
        .i_slot        (i_req.slot),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_result_slot (o_rsp.result_slot),
        .o_link_slot   (o_rsp.link_slot),
        .o_byte_offset (o_rsp.byte_offset),
        .o_used_count  (o_rsp.used_count),
        .o_free_count  (o_rsp.free_count),
        .o_page_empty  (o_rsp.page_empty)
    );

    assign i_req.ready = req_ready;

endmodule

### hw/rtl/pslm_checker.sv
// Port-level checker of the page slot list manager and its bind to the top level.
// Depends on pslm_pkg and page_slot_list_manager_top_assert.svh.
`include "page_slot_list_manager_top_assert.svh"

module pslm_checker
    import pslm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [SLOT_W-1:0]   i_result_slot,
    input logic [SLOT_W-1:0]   i_link_slot,
    input logic [OFF_W-1:0]    i_byte_offset,
    input logic [SLOT_W-1:0]   i_used_count,
    input logic [SLOT_W-1:0]   i_free_count,
    input logic                i_page_empty
);

    // A waiting result stays valid and keeps its slot and offset until it is taken.
    `PSLM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_result_slot) && $stable(i_byte_offset), "result changed while stalled")

    // A failed request carries no offset and never flags an empty page.
    `PSLM_ASSERT_IMPLY(a_fail_clean, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_OK), (i_byte_offset == '0) && !i_page_empty, "failed request carries offset or empty flag")

    // A full page hands out no slot.
    `PSLM_ASSERT_IMPLY(a_full_null, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_FULL), (i_result_slot == NULL_SLOT) && (i_link_slot == NULL_SLOT), "full result names a slot")

    // The empty flag agrees with the used count.
    `PSLM_ASSERT_IMPLY(a_empty_count, i_clk, i_rst_n, i_rsp_valid && i_page_empty, (i_used_count == '0) && (i_status == ST_OK), "page empty with records in use")

    // Used and free slots together never exceed the page.
    `PSLM_ASSERT_IMPLY(a_count_sum, i_clk, i_rst_n, i_rsp_valid, ({1'b0, i_used_count} + {1'b0, i_free_count}) <= {1'b0, NULL_SLOT}, "slot counts exceed page")

endmodule

bind page_slot_list_manager_top pslm_checker u_pslm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_result_slot (o_rsp.result_slot),
    .i_link_slot   (o_rsp.link_slot),
    .i_byte_offset (o_rsp.byte_offset),
    .i_used_count  (o_rsp.used_count),
    .i_free_count  (o_rsp.free_count),
    .i_page_empty  (o_rsp.page_empty)
);
